/* hw/rtl/sem_pkg.sv */
package sem_pkg;

    // Default sizes of the line stores and of the frame height limit
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;

    // Frame size after reset
    localparam int WIDTH_RST  = 640;
    localparam int HEIGHT_RST = 480;

    // Saturation level of the gradient magnitude
    localparam int EDGE_MAX = 255;

    // Configuration register fields
    localparam int CFG_WIDTH_W  = 11;
    localparam int CFG_HEIGHT_W = 13;
    localparam int APB_ADDR_W   = 3;
    localparam int APB_DATA_W   = 32;

    // Register indexes
    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } sem_reg_idx_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic       capture;
        logic       load_size;
        logic       load_total;
        logic       div_step;
        logic       div_done;
        logic       update;
        logic       sq_x;
        logic       sq_y;
        logic       root;
        logic       round;
        logic       emit;
        logic [1:0] ch;
        logic [2:0] bit_idx;
    } sem_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic has_result;
        logic out_free;
    } sem_sts_t;

endpackage

/* hw/rtl/sem_ctrl.sv */
module sem_ctrl #(
    parameter int DIV_STEPS = 23
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              cfg_wr,
    input  sem_pkg::sem_sts_t sts,
    output sem_pkg::sem_cmd_t cmd,
    output logic              in_stall
);
    import sem_pkg::*;

    localparam int CW = $clog2(DIV_STEPS + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_SIZE,
        S_TOTAL,
        S_DIV,
        S_DIV_DONE,
        S_UPDATE,
        S_SQ_X,
        S_SQ_Y,
        S_ROOT,
        S_ROUND,
        S_EMIT
    } state_t;

    state_t         state_reg, state_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [1:0]     ch_reg, ch_next;
    logic [2:0]     bit_reg, bit_next;
    logic           cfg_pend_reg, cfg_pend_next;
    logic           cfg_go;
    logic           accept;

    // A write seen while busy waits until the sequencer is idle again
    assign cfg_go   = cfg_wr || cfg_pend_reg;
    assign in_stall = (state_reg != S_IDLE) || cfg_go;
    assign accept   = in_valid && (state_reg == S_IDLE) && !cfg_go;

    // Next state and counters
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        ch_next       = ch_reg;
        bit_next      = bit_reg;
        cfg_pend_next = cfg_pend_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_go)
                begin
                    state_next    = S_SIZE;
                    cfg_pend_next = 1'b0;
                end
                else if (in_valid)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_SIZE:
            begin
                state_next = S_TOTAL;
            end
            S_TOTAL:
            begin
                state_next = S_DIV;
                cnt_next   = '0;
            end
            S_DIV:
            begin
                cnt_next = cnt_reg + CW'(1);
                if (cnt_reg == CW'(DIV_STEPS - 1))
                begin
                    state_next = S_DIV_DONE;
                end
            end
            S_DIV_DONE:
            begin
                state_next = S_IDLE;
            end
            S_UPDATE:
            begin
                ch_next    = 2'd0;
                state_next = sts.has_result ? S_SQ_X : S_IDLE;
            end
            S_SQ_X:
            begin
                state_next = S_SQ_Y;
            end
            S_SQ_Y:
            begin
                bit_next   = 3'd0;
                state_next = S_ROOT;
            end
            S_ROOT:
            begin
                bit_next = bit_reg + 3'd1;
                if (bit_reg == 3'd7)
                begin
                    state_next = S_ROUND;
                end
            end
            S_ROUND:
            begin
                if (ch_reg == 2'd2)
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    ch_next    = ch_reg + 2'd1;
                    state_next = S_SQ_X;
                end
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        if (cfg_wr && (state_reg != S_IDLE))
        begin
            cfg_pend_next = 1'b1;
        end
    end

    // Hold state and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= '0;
            ch_reg       <= '0;
            bit_reg      <= '0;
            cfg_pend_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            ch_reg       <= ch_next;
            bit_reg      <= bit_next;
            cfg_pend_reg <= cfg_pend_next;
        end
    end

    // Decode commands
    always_comb
    begin
        cmd            = '0;
        cmd.capture    = accept;
        cmd.load_size  = (state_reg == S_SIZE);
        cmd.load_total = (state_reg == S_TOTAL);
        cmd.div_step   = (state_reg == S_DIV);
        cmd.div_done   = (state_reg == S_DIV_DONE);
        cmd.update     = (state_reg == S_UPDATE);
        cmd.sq_x       = (state_reg == S_SQ_X);
        cmd.sq_y       = (state_reg == S_SQ_Y);
        cmd.root       = (state_reg == S_ROOT);
        cmd.round      = (state_reg == S_ROUND);
        cmd.emit       = (state_reg == S_EMIT) && sts.out_free;
        cmd.ch         = ch_reg;
        cmd.bit_idx    = bit_reg;
    end

    a_root_ends: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROOT && bit_reg == 3'd7 |=> state_reg == S_ROUND)
        else $error("root extraction did not end after eight steps");

    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT && !sts.out_free |=> state_reg == S_EMIT)
        else $error("result dropped while output register was full");

    a_no_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UPDATE && !sts.has_result |=> state_reg == S_IDLE)
        else $error("item without result went on to compute");

endmodule

/* hw/rtl/sem_dp.sv */
module sem_dp #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int PW         = 23
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sem_pkg::sem_cmd_t                  cmd,
    output sem_pkg::sem_sts_t                  sts,
    input  logic [sem_pkg::CFG_WIDTH_W-1:0]    cfg_width,
    input  logic [sem_pkg::CFG_HEIGHT_W-1:0]   cfg_height,
    input  logic [7:0]                         in_red,
    input  logic [7:0]                         in_green,
    input  logic [7:0]                         in_blue,
    input  logic                               is_drain,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [7:0]                         edge_red,
    output logic [7:0]                         edge_green,
    output logic [7:0]                         edge_blue,
    output logic                               frame_end
);
    import sem_pkg::*;

    localparam int WW    = $clog2(MAX_WIDTH + 1);
    localparam int HW    = $clog2(MAX_HEIGHT + 1);
    localparam int XW    = $clog2(MAX_WIDTH);
    localparam int W_RST = (WIDTH_RST > MAX_WIDTH) ? MAX_WIDTH : WIDTH_RST;
    localparam int H_RST = (HEIGHT_RST > MAX_HEIGHT) ? MAX_HEIGHT : HEIGHT_RST;
    localparam int T_RST = W_RST * H_RST;
    localparam int SW    = 21;

    // Line stores
    logic [23:0] upper_mem [MAX_WIDTH];
    logic [23:0] lower_mem [MAX_WIDTH];
    logic [23:0] upper_rd_reg;
    logic [23:0] lower_rd_reg;
    logic [23:0] pix_reg;

    // Frame size and position
    logic [WW-1:0] wc_reg;
    logic [HW-1:0] hc_reg;
    logic [PW-1:0] total_reg;
    logic [PW-1:0] p_reg;
    logic [XW-1:0] x_reg;
    logic [PW-1:0] y_reg;
    logic [WW-1:0] rem_reg;

    // Window and computation
    logic [23:0]   win_reg  [9];
    logic [23:0]   view_reg [9];
    logic [23:0]   view_next [9];
    logic [23:0]   col [3];
    logic          fe_reg;
    logic [SW-1:0] s_reg;
    logic [7:0]    n_reg;
    logic [7:0]    res_reg [3];
    logic          out_valid_reg;
    logic [7:0]    out_r_reg, out_g_reg, out_b_reg;
    logic          out_fe_reg;

    // Size clamping
    logic [WW-1:0] wc_next;
    logic [HW-1:0] hc_next;

    always_comb
    begin
        priority if (cfg_width == '0)
        begin
            wc_next = WW'(1);
        end
        else if (32'(cfg_width) > 32'(MAX_WIDTH))
        begin
            wc_next = WW'(MAX_WIDTH);
        end
        else
        begin
            wc_next = WW'(cfg_width);
        end
        priority if (cfg_height == '0)
        begin
            hc_next = HW'(1);
        end
        else if (32'(cfg_height) > 32'(MAX_HEIGHT))
        begin
            hc_next = HW'(MAX_HEIGHT);
        end
        else
        begin
            hc_next = HW'(cfg_height);
        end
    end

    // Position tests
    logic [PW-1:0] wc_p, hc_p, end_pos;
    logic          has_result, wrap, is_last, xz;
    logic          r0_ok, r2_ok, c0_ok;
    logic [WW:0]   trial;
    logic          trial_ok;

    assign wc_p       = PW'(wc_reg);
    assign hc_p       = PW'(hc_reg);
    assign end_pos    = total_reg + wc_p;
    assign has_result = (p_reg > wc_p) && (p_reg <= end_pos);
    assign wrap       = (p_reg >= end_pos);
    assign is_last    = (p_reg == end_pos);
    assign xz         = (x_reg == '0);
    assign r0_ok      = xz ? (y_reg >= PW'(3)) : (y_reg >= PW'(2));
    assign r2_ok      = xz ? (y_reg <= hc_p) : (y_reg < hc_p);
    assign c0_ok      = xz ? (wc_reg >= WW'(2)) : (x_reg >= XW'(2));
    assign trial      = {rem_reg, y_reg[PW-1]} - {1'b0, wc_reg};
    assign trial_ok   = ({rem_reg, y_reg[PW-1]} >= {1'b0, wc_reg});

    // Build the masked view
    always_comb
    begin
        logic rok;
        col[0] = upper_rd_reg;
        col[1] = lower_rd_reg;
        col[2] = pix_reg;
        for (int r = 0; r < 3; r++)
        begin
            rok = (r == 0) ? r0_ok : ((r == 2) ? r2_ok : 1'b1);
            view_next[r*3+0] = (rok && c0_ok) ? win_reg[r*3+1] : 24'd0;
            view_next[r*3+1] = rok ? win_reg[r*3+2] : 24'd0;
            view_next[r*3+2] = (rok && !xz) ? col[r] : 24'd0;
        end
    end

    // Gradients of the selected channel
    logic [7:0]         v [9];
    logic signed [10:0] gx, gy;
    logic signed [21:0] g_sq;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            unique case (cmd.ch)
                2'd0:    v[i] = view_reg[i][23:16];
                2'd1:    v[i] = view_reg[i][15:8];
                default: v[i] = view_reg[i][7:0];
            endcase
        end
        gx = (11'(v[2]) + (11'(v[5]) << 1) + 11'(v[8]))
           - (11'(v[0]) + (11'(v[3]) << 1) + 11'(v[6]));
        gy = (11'(v[6]) + (11'(v[7]) << 1) + 11'(v[8]))
           - (11'(v[0]) + (11'(v[1]) << 1) + 11'(v[2]));
        g_sq = cmd.sq_x ? (gx * gx) : (gy * gy);
    end

    // Root step and rounding
    logic [7:0]  t_bit, t_try, n_inc;
    logic [15:0] t_sq, n_lim;
    logic        sat;

    assign t_bit = 8'(8'h80 >> cmd.bit_idx);
    assign t_try = n_reg | t_bit;
    assign t_sq  = 16'(t_try) * 16'(t_try);
    assign n_lim = 16'(n_reg) * 16'(n_reg) + 16'(n_reg);
    assign sat   = (s_reg > SW'(EDGE_MAX * EDGE_MAX + EDGE_MAX));
    assign n_inc = (s_reg > SW'(n_lim)) ? (n_reg + 8'd1) : n_reg;

    // Line store access
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            upper_rd_reg <= upper_mem[x_reg];
            lower_rd_reg <= lower_mem[x_reg];
        end
        if (cmd.update)
        begin
            upper_mem[x_reg] <= lower_rd_reg;
            lower_mem[x_reg] <= pix_reg;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            pix_reg <= is_drain ? 24'd0 : {in_red, in_green, in_blue};
        end
        if (cmd.update)
        begin
            view_reg <= view_next;
            fe_reg   <= is_last;
        end
        if (cmd.sq_x)
        begin
            s_reg <= SW'(g_sq);
            n_reg <= 8'd0;
        end
        if (cmd.sq_y)
        begin
            s_reg <= s_reg + SW'(g_sq);
        end
        if (cmd.root && ({5'd0, t_sq} <= s_reg))
        begin
            n_reg <= t_try;
        end
        if (cmd.round)
        begin
            res_reg[cmd.ch] <= sat ? 8'(EDGE_MAX) : n_inc;
        end
        if (cmd.emit)
        begin
            out_r_reg  <= res_reg[0];
            out_g_reg  <= res_reg[1];
            out_b_reg  <= res_reg[2];
            out_fe_reg <= fe_reg;
        end
    end

    // Control state: size, position, window, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wc_reg        <= WW'(W_RST);
            hc_reg        <= HW'(H_RST);
            total_reg     <= PW'(T_RST);
            p_reg         <= '0;
            x_reg         <= '0;
            y_reg         <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 9; i++)
            begin
                win_reg[i] <= 24'd0;
            end
        end
        else
        begin
            if (cmd.load_size)
            begin
                wc_reg <= wc_next;
                hc_reg <= hc_next;
            end
            if (cmd.load_total)
            begin
                total_reg <= PW'(wc_p * hc_p);
                y_reg     <= p_reg;
                rem_reg   <= '0;
            end
            if (cmd.div_step)
            begin
                y_reg   <= {y_reg[PW-2:0], trial_ok};
                rem_reg <= trial_ok ? WW'(trial) : {rem_reg[WW-2:0], y_reg[PW-1]};
            end
            if (cmd.div_done)
            begin
                x_reg <= XW'(rem_reg);
            end
            if (cmd.update)
            begin
                for (int r = 0; r < 3; r++)
                begin
                    win_reg[r*3+0] <= win_reg[r*3+1];
                    win_reg[r*3+1] <= win_reg[r*3+2];
                    win_reg[r*3+2] <= col[r];
                end
                priority if (wrap)
                begin
                    p_reg <= '0;
                    x_reg <= '0;
                    y_reg <= '0;
                end
                else if (WW'(x_reg) + WW'(1) == wc_reg)
                begin
                    p_reg <= p_reg + PW'(1);
                    x_reg <= '0;
                    y_reg <= y_reg + PW'(1);
                end
                else
                begin
                    p_reg <= p_reg + PW'(1);
                    x_reg <= x_reg + XW'(1);
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign sts.has_result = has_result;
    assign sts.out_free   = !out_valid_reg || !out_stall;

    assign out_valid  = out_valid_reg;
    assign edge_red   = out_r_reg;
    assign edge_green = out_g_reg;
    assign edge_blue  = out_b_reg;
    assign frame_end  = out_fe_reg;

    a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> WW'(x_reg) < wc_reg)
        else $error("column position outside the row");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!out_valid_reg || !out_stall))
        else $error("output register overwritten while held");

    a_last_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update && is_last |=> p_reg == '0)
        else $error("position did not wrap after the frame's last result");

endmodule

/* hw/rtl/sobel_edge_magnitude_core.sv */
// Sobel edge magnitude core for a raster-ordered RGB pixel stream.
// Input channel: in_valid/in_stall with in_red, in_green, in_blue, is_drain.
//   An item moves when in_valid is high and in_stall is low. After the last
//   pixel of each frame send frame_width+1 items with is_drain set.
// Output channel: out_valid/out_stall with edge_red, edge_green, edge_blue
//   and frame_end. Result k appears after input item k+W+1; frame_end marks
//   the result of the frame's last pixel.
// Each item is handled alone by a sequencer: it is accepted, then the line
//   store update and window shift follow, then per color both gradients are
//   squared, a bit-serial root is extracted and rounded. An item with a result
//   then goes to the output register; one without returns to idle after the update.
//   The bit-serial square root is shared by the three colors.
// The output register frees the sequencer: the next item is accepted while a
//   result waits under out_stall; a further result then waits in the
//   sequencer until the output register empties.
// Configuration: APB, frame_width at 0x0, frame_height at 0x4. After a write
//   the core stalls input while it resolves the stream position against the new
//   width by bit-serial division; a write landing meanwhile repeats the sequence.
// Reset: 640x480 frame, position zero, window cleared, no result pending.
module sobel_edge_magnitude_core #(
    parameter int MAX_WIDTH  = sem_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = sem_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [sem_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [sem_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [sem_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [7:0]                        in_red,
    input  logic [7:0]                        in_green,
    input  logic [7:0]                        in_blue,
    input  logic                              is_drain,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [7:0]                        edge_red,
    output logic [7:0]                        edge_green,
    output logic [7:0]                        edge_blue,
    output logic                              frame_end
);
    import sem_pkg::*;

    localparam int PW = $clog2(MAX_WIDTH * (MAX_HEIGHT + 1) + 1);

    logic [CFG_WIDTH_W-1:0]  width_reg;
    logic [CFG_HEIGHT_W-1:0] height_reg;
    logic                    wr_en;
    logic                    cfg_wr;
    sem_reg_idx_t            reg_idx;
    sem_cmd_t                cmd;
    sem_sts_t                sts;

    assign pready  = 1'b1;
    assign reg_idx = sem_reg_idx_t'(paddr[2]);
    assign wr_en   = psel && penable && pwrite && (paddr[1:0] == 2'b00);
    assign cfg_wr  = wr_en;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= CFG_WIDTH_W'(WIDTH_RST);
            height_reg <= CFG_HEIGHT_W'(HEIGHT_RST);
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_FRAME_WIDTH:  width_reg  <= pwdata[CFG_WIDTH_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= pwdata[CFG_HEIGHT_W-1:0];
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    // Register readback
    always_comb
    begin
        unique case (reg_idx)
            REG_FRAME_WIDTH:  prdata = APB_DATA_W'(width_reg);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(height_reg);
            default:          prdata = '0;
        endcase
        if (paddr[1:0] != 2'b00)
        begin
            prdata = '0;
        end
    end

    sem_ctrl #(
        .DIV_STEPS (PW)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cfg_wr   (cfg_wr),
        .sts      (sts),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    sem_dp #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PW         (PW)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .sts        (sts),
        .cfg_width  (width_reg),
        .cfg_height (height_reg),
        .in_red     (in_red),
        .in_green   (in_green),
        .in_blue    (in_blue),
        .is_drain   (is_drain),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .edge_red   (edge_red),
        .edge_green (edge_green),
        .edge_blue  (edge_blue),
        .frame_end  (frame_end)
    );

endmodule
